// ----- src/assert_macros.svh -----
// assertion macros for the deque rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define DEQU_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define DEQU_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/dequ_pkg.sv -----
// operation codes and widths shared by the deque rtl
package dequ_pkg;

    localparam int KIND_W = 3;

    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t KIND_PUSH_FRONT = 3'd0;
    localparam kind_t KIND_PUSH_REAR  = 3'd1;
    localparam kind_t KIND_POP_FRONT  = 3'd2;
    localparam kind_t KIND_POP_REAR   = 3'd3;
    localparam kind_t KIND_CLEAR      = 3'd4;

endpackage

// ----- src/dequ_store.sv -----
// element ring store, one write port and one registered read port
module dequ_store #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int AW         = 4
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  logic [DATA_WIDTH-1:0] wdata,
    input  logic                  re,
    input  logic [AW-1:0]         raddr,
    output logic [DATA_WIDTH-1:0] rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/dequ_ctrl.sv -----
// deque index, count and sequencing logic with the result register
`include "assert_macros.svh"

module dequ_ctrl
    import dequ_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int AW         = 4,
    parameter int CW         = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  kind_t                 kind,
    input  logic [DATA_WIDTH-1:0] push_value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_WIDTH-1:0] pop_value,
    output logic                  underflow,
    output logic                  overflow,
    output logic [CW-1:0]         occupancy,
    output logic                  is_empty,
    output logic                  mem_we,
    output logic [AW-1:0]         mem_waddr,
    output logic [DATA_WIDTH-1:0] mem_wdata,
    output logic                  mem_re,
    output logic [AW-1:0]         mem_raddr,
    input  logic [DATA_WIDTH-1:0] mem_rdata
);

    typedef enum logic {S_IDLE, S_READ} state_t;

    state_t                state_reg;
    logic [AW-1:0]         head_reg, head_next;
    logic [AW-1:0]         tail_reg, tail_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  out_valid_reg;
    logic [DATA_WIDTH-1:0] pop_value_reg;
    logic                  underflow_reg;
    logic                  overflow_reg;
    logic [CW-1:0]         occupancy_reg;

    logic          accept;
    logic          full;
    logic          empty;
    logic          under;
    logic          over;
    logic [AW-1:0] head_inc, head_dec, tail_inc, tail_dec;

    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - 1'b1;
    assign tail_inc = (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? AW'(DEPTH - 1) : tail_reg - 1'b1;

    assign mem_wdata = push_value;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        under      = 1'b0;
        over       = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = head_dec;
        mem_re     = 1'b0;
        mem_raddr  = head_reg;
        unique case (kind)
            KIND_PUSH_FRONT:
            begin
                if (full)
                begin
                    over = 1'b1;
                end
                else
                begin
                    mem_we     = accept;
                    mem_waddr  = head_dec;
                    head_next  = head_dec;
                    count_next = count_reg + 1'b1;
                end
            end
            KIND_PUSH_REAR:
            begin
                if (full)
                begin
                    over = 1'b1;
                end
                else
                begin
                    mem_we     = accept;
                    mem_waddr  = tail_reg;
                    tail_next  = tail_inc;
                    count_next = count_reg + 1'b1;
                end
            end
            KIND_POP_FRONT:
            begin
                if (empty)
                begin
                    under = 1'b1;
                end
                else
                begin
                    mem_re     = accept;
                    mem_raddr  = head_reg;
                    head_next  = head_inc;
                    count_next = count_reg - 1'b1;
                end
            end
            KIND_POP_REAR:
            begin
                if (empty)
                begin
                    under = 1'b1;
                end
                else
                begin
                    mem_re     = accept;
                    mem_raddr  = tail_dec;
                    tail_next  = tail_dec;
                    count_next = count_reg - 1'b1;
                end
            end
            KIND_CLEAR:
            begin
                head_next  = '0;
                tail_next  = '0;
                count_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            pop_value_reg <= '0;
            underflow_reg <= 1'b0;
            overflow_reg  <= 1'b0;
            occupancy_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        head_reg      <= head_next;
                        tail_reg      <= tail_next;
                        count_reg     <= count_next;
                        occupancy_reg <= count_next;
                        underflow_reg <= under;
                        overflow_reg  <= over;
                        pop_value_reg <= '0;
                        if (mem_re)
                        begin
                            // result waits for the store read
                            state_reg     <= S_READ;
                            out_valid_reg <= 1'b0;
                        end
                        else
                        begin
                            out_valid_reg <= 1'b1;
                        end
                    end
                    else if (out_valid_reg && out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end
                S_READ:
                begin
                    pop_value_reg <= mem_rdata;
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign pop_value = pop_value_reg;
    assign underflow = underflow_reg;
    assign overflow  = overflow_reg;
    assign occupancy = occupancy_reg;
    assign is_empty  = (occupancy_reg == '0);

    `DEQU_ASSERT(a_count_bound, count_reg <= CW'(DEPTH), "element count above depth")
    `DEQU_ASSERT(a_no_rw_overlap, !(mem_we && mem_re), "store written and read together")
    `DEQU_ASSERT(a_read_slot_free, (state_reg == S_READ) |-> !out_valid_reg, "result slot busy during read")
    `DEQU_ASSERT(a_read_delivers, (state_reg == S_READ) |=> (out_valid_reg && state_reg == S_IDLE), "pop result not loaded after read")
    `DEQU_ASSERT(a_flags_exclusive, out_valid_reg |-> !(underflow_reg && overflow_reg), "both flags raised")

endmodule

// ----- src/double_ended_queue_unit.sv -----
// top level of the bounded double-ended queue
//
// input channel: in_valid/in_ready carry kind and push_value; kind selects
// push front, push rear, pop front, pop rear or clear, other codes do nothing
// output channel: out_valid/out_ready carry one result per input beat:
// pop_value, underflow, overflow, occupancy and is_empty after the operation
// result timing: a push, clear, empty pop or unused code gives its result in
// the cycle after the input beat; a pop that removes an element first passes
// through S_READ, since the element comes from the synchronous store read port
// throughput: one beat per cycle for non-pop operations while results are
// taken; a pop that returns an element holds in_ready low while in S_READ
// a new beat is taken while the previous result is being taken in the same
// cycle; while the receiver stalls with a result held, in_ready stays low
// reset: the queue is empty, indices and count are zero, no result is pending;
// the store contents are not cleared and are never read before being written
module double_ended_queue_unit
    import dequ_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [KIND_W-1:0]             kind,
    input  logic [DATA_WIDTH-1:0]         push_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [DATA_WIDTH-1:0]         pop_value,
    output logic                          underflow,
    output logic                          overflow,
    output logic [$clog2(DEPTH+1)-1:0]    occupancy,
    output logic                          is_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;

    dequ_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW),
        .CW         (CW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind_t'(kind)),
        .push_value (push_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pop_value  (pop_value),
        .underflow  (underflow),
        .overflow   (overflow),
        .occupancy  (occupancy),
        .is_empty   (is_empty),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    dequ_store #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
